/* design/genomic_relationship_matrix_macros.svh */
// assertion macros for the genomic relationship matrix block
`ifndef GENOMIC_RELATIONSHIP_MATRIX_MACROS_SVH
`define GENOMIC_RELATIONSHIP_MATRIX_MACROS_SVH

// same-cycle implication, sampled on the block clock
`define GRM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define GRM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* design/grm_pkg.sv */
// shared constants, codes and types of the genomic relationship matrix block
package grm_pkg;

   localparam int MAX_SAMPLES = 64;
   localparam int MAX_MARKERS = 1024;
   localparam int SAMPLE_W    = 6;
   localparam int MARKER_W    = 10;
   localparam int GENO_ADDR_W = SAMPLE_W + MARKER_W;
   localparam int REL_ADDR_W  = 2 * SAMPLE_W;
   localparam int CODE_W      = 19;
   localparam int PROD_W      = 2 * CODE_W;
   localparam int ACC_W       = 48;
   localparam int DEN_W       = 41;
   localparam int DIV_W       = 64;
   localparam int DIV_CNT_W   = 6;

   localparam logic [1:0] CMD_LOAD    = 2'd0;
   localparam logic [1:0] CMD_COMPUTE = 2'd1;
   localparam logic [1:0] CMD_READ    = 2'd2;

   localparam logic [1:0] ST_READ     = 2'd0;
   localparam logic [1:0] ST_DONE     = 2'd1;
   localparam logic [1:0] ST_ZERO_DEN = 2'd2;

   localparam logic [1:0] REG_MODE    = 2'd0;
   localparam logic [1:0] REG_SAMPLES = 2'd1;
   localparam logic [1:0] REG_MARKERS = 2'd2;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_RD_WAIT,
      S_F_SCAN,
      S_F_DRAIN,
      S_F_START,
      S_F_DIVW,
      S_F_MUL_PQ,
      S_F_MUL_PP,
      S_F_MUL_QQ,
      S_F_MUL_HH,
      S_F_WRITE,
      S_M_CLEAR,
      S_M_MAC,
      S_M_DRAIN,
      S_M_DIV,
      S_M_DIVW,
      S_M_WR1,
      S_M_WR2,
      S_DONE
   } state_type;

endpackage

/* design/grm_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
module grm_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [grm_pkg::DIV_W-1:0]     dividend,
   input  logic [grm_pkg::DEN_W-1:0]     divisor,
   output grm_pkg::div_status_type       status,
   output logic [grm_pkg::DIV_W-1:0]     quotient
);
   import grm_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] count_ff;
   logic [DEN_W-1:0]     rem_ff;
   logic [DEN_W-1:0]     dvs_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [DEN_W:0]       trial;
   logic [DEN_W:0]       diff;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == {DIV_CNT_W{1'b1}}) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath: dividend shifts out while quotient bits shift in
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
         rem_ff <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

/* design/genomic_relationship_matrix.sv */
// genomic relationship matrix engine: genotype store, frequency pass and matrix pass
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   command, sample/marker index, code, row/col
//   rsp      out        rsp_valid/rsp_stall   entry_value (Q16.16), status
//   csr      in/out     apb write/read        mode, samples_in_use, markers_in_use
//
// load requests are taken back to back while idle; a read request passes through the
// registered relationship memory read, then the output register
// compute: per marker an ns scan, drain, start, a shared divide, 4 multiplies and a write
// (no divide for an all-missing marker), a clearing sweep of the relationship memory,
// then, unless the denominator is zero, per pair (i<=j) a pipelined multiply-accumulate
// over nm markers with drain, a divide and two writes; then a done state
// reset clears control and configuration; memories hold no reset value
// a result waits in the output register under rsp_stall; only loads are taken meanwhile
module genomic_relationship_matrix (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_command,
   input  logic [5:0]             req_sample_index,
   input  logic [9:0]             req_marker_index,
   input  logic [1:0]             req_genotype_code,
   input  logic [5:0]             req_row_index,
   input  logic [5:0]             req_col_index,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [31:0]     rsp_entry_value,
   output logic [1:0]             rsp_status,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [3:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   import grm_pkg::*;

   // configuration
   logic        mode_ff;
   logic [6:0]  samples_ff;
   logic [10:0] markers_ff;
   logic        csr_wr;

   // state machine
   state_type state_ff, state_in;

   // memories
   logic [1:0]          geno_mem [MAX_SAMPLES*MAX_MARKERS];
   logic [3*CODE_W-1:0] code_mem [MAX_MARKERS];
   logic [31:0]         rel_mem  [MAX_SAMPLES*MAX_SAMPLES];
   logic [1:0]          ga_ff, gb_ff;
   logic [3*CODE_W-1:0] code_rd_ff;
   logic [31:0]         rel_rd_ff;
   logic [GENO_ADDR_W-1:0] geno_raddr_a, geno_raddr_b;
   logic [REL_ADDR_W-1:0]  rel_waddr;
   logic [31:0]            rel_wdata;
   logic                   rel_we;

   // counters
   logic [SAMPLE_W-1:0]   i_ff, j_ff;
   logic [MARKER_W-1:0]   m_ff;
   logic [REL_ADDR_W-1:0] clr_ff;
   logic [SAMPLE_W-1:0]   ns_last;
   logic [MARKER_W-1:0]   nm_last;

   // frequency pass
   logic [7:0]  sum_ff;
   logic [6:0]  cnt_ff;
   logic        scan_v_ff;
   logic [16:0] p_ff;
   logic [16:0] q_val;
   logic [16:0] het_ff;
   logic [17:0] cpp_ff, cqq_ff;
   logic        czero_ff;
   logic [DEN_W-1:0] den_ff;
   logic [PROD_W-1:0] prod_rnd;
   logic signed [CODE_W-1:0] twop;
   logic [3*CODE_W-1:0] code_wdata;

   // shared multiplier and accumulator
   logic signed [CODE_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic                     mac_v1_ff, mac_v2_ff;

   // shared divider
   logic                 div_start;
   logic [DIV_W-1:0]     div_dividend;
   logic [DEN_W-1:0]     div_divisor;
   div_status_type       div_stat;
   logic [DIV_W-1:0]     div_quo;
   logic [ACC_W-1:0]     mag;
   logic [DIV_W-1:0]     ratio_num;
   logic                 q_hi;
   logic [31:0]          ratio_val;
   logic [31:0]          res_ff;

   // output and status
   logic        matrix_ready_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_value_ff;
   logic [1:0]  rsp_status_ff;
   logic        req_fire;

   function automatic logic signed [CODE_W-1:0] pick_code(
      input logic [3*CODE_W-1:0] codes,
      input logic [1:0]          g
   );
      logic signed [CODE_W-1:0] v;
      unique case (g)
         2'd0:    v = signed'(codes[CODE_W-1:0]);
         2'd1:    v = signed'(codes[2*CODE_W-1:CODE_W]);
         2'd2:    v = signed'(codes[3*CODE_W-1:2*CODE_W]);
         default: v = '0;   // missing genotype
      endcase
      return v;
   endfunction

   function automatic logic [10:0] clamp_count(input logic [10:0] v, input logic [10:0] hi);
      logic [10:0] r;
      priority if (v == 11'd0) r = 11'd1;
      else if (v > hi)         r = hi;
      else                     r = v;
      return r;
   endfunction

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         samples_ff <= 7'(MAX_SAMPLES);
         markers_ff <= 11'(MAX_MARKERS);
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_MODE:    mode_ff    <= csr_pwdata[0];
            REG_SAMPLES: samples_ff <= 7'(clamp_count({4'd0, csr_pwdata[6:0]},
                                                       11'(MAX_SAMPLES)));
            REG_MARKERS: markers_ff <= clamp_count(csr_pwdata[10:0], 11'(MAX_MARKERS));
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_MODE:    csr_prdata = {31'd0, mode_ff};
         REG_SAMPLES: csr_prdata = {25'd0, samples_ff};
         REG_MARKERS: csr_prdata = {21'd0, markers_ff};
         default:     csr_prdata = '0;
      endcase
   end

   assign ns_last = SAMPLE_W'(samples_ff - 7'd1);
   assign nm_last = MARKER_W'(markers_ff - 11'd1);

   // ---------------- request handshake ----------------
   // loads go on while a result waits; compute and read need the output free
   assign req_stall = (state_ff != S_IDLE) ||
                      (rsp_valid_ff && rsp_stall && (req_command != CMD_LOAD));
   assign req_fire  = req_valid && !req_stall;

   // ---------------- memories ----------------
   assign geno_raddr_a = {i_ff, m_ff};
   assign geno_raddr_b = {j_ff, m_ff};

   always_ff @(posedge clock) begin
      if (req_fire && (req_command == CMD_LOAD)) begin
         geno_mem[{req_sample_index, req_marker_index}] <= req_genotype_code;
      end
      ga_ff <= geno_mem[geno_raddr_a];
      gb_ff <= geno_mem[geno_raddr_b];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_F_WRITE) begin
         code_mem[m_ff] <= code_wdata;
      end
      code_rd_ff <= code_mem[m_ff];
   end

   always_ff @(posedge clock) begin
      if (rel_we) begin
         rel_mem[rel_waddr] <= rel_wdata;
      end
      rel_rd_ff <= rel_mem[{req_row_index, req_col_index}];
   end

   // ---------------- shared multiplier ----------------
   assign q_val = 17'd65536 - p_ff;

   always_comb begin
      unique case (state_ff)
         S_F_MUL_PQ: begin
            mul_a = signed'({2'b00, p_ff});
            mul_b = signed'({2'b00, q_val});
         end
         S_F_MUL_PP: begin
            mul_a = signed'({2'b00, p_ff});
            mul_b = signed'({2'b00, p_ff});
         end
         S_F_MUL_QQ: begin
            mul_a = signed'({2'b00, q_val});
            mul_b = signed'({2'b00, q_val});
         end
         S_F_MUL_HH: begin
            mul_a = signed'({2'b00, het_ff});
            mul_b = signed'({2'b00, het_ff});
         end
         default: begin
            // matrix pass: codes picked by the two genotypes of this marker
            mul_a = pick_code(code_rd_ff, ga_ff);
            mul_b = pick_code(code_rd_ff, gb_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // round(2*x / 2^16) for a non-negative product
   assign prod_rnd = $unsigned(prod_ff) + PROD_W'(16384);

   // per-marker code triple for genotypes 0, 1, 2
   assign twop = signed'({1'b0, p_ff, 1'b0});

   always_comb begin
      priority if (czero_ff) begin
         code_wdata = '0;   // all-missing marker
      end else if (mode_ff) begin
         code_wdata = {-signed'({1'b0, cqq_ff}),
                       signed'({2'b00, het_ff}),
                       -signed'({1'b0, cpp_ff})};
      end else begin
         code_wdata = {CODE_W'(19'sd131072 - twop),
                       CODE_W'(19'sd65536 - twop),
                       CODE_W'(-twop)};
      end
   end

   // ---------------- shared divider ----------------
   assign mag       = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign ratio_num = (mode_ff ? {mag, 16'd0} : {16'd0, mag}) +
                      {24'd0, den_ff[DEN_W-1:1]};
   assign div_dividend = (state_ff == S_M_DIV) ? ratio_num
                                               : ({40'd0, sum_ff, 16'd0} + DIV_W'(cnt_ff));
   assign div_divisor  = (state_ff == S_M_DIV) ? den_ff : {33'd0, cnt_ff, 1'b0};

   grm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_stat),
      .quotient (div_quo)
   );

   // saturate the rounded magnitude into signed 32 bits
   assign q_hi = |div_quo[DIV_W-1:31];
   always_comb begin
      priority if (!acc_ff[ACC_W-1]) ratio_val = q_hi ? 32'h7FFF_FFFF : div_quo[31:0];
      else                           ratio_val = q_hi ? 32'h8000_0000 : -div_quo[31:0];
   end

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      rel_we    = 1'b0;
      rel_waddr = clr_ff;
      rel_wdata = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               priority case (req_command)
                  CMD_COMPUTE: state_in = S_F_SCAN;
                  CMD_READ:    state_in = S_RD_WAIT;
                  default: ;   // load or unused command
               endcase
            end
         end
         S_RD_WAIT: state_in = S_IDLE;
         S_F_SCAN:  if (i_ff == ns_last) state_in = S_F_DRAIN;
         S_F_DRAIN: state_in = S_F_START;
         S_F_START: begin
            if (cnt_ff == 7'd0) begin
               state_in = S_F_MUL_PQ;
            end else begin
               div_start = 1'b1;
               state_in  = S_F_DIVW;
            end
         end
         S_F_DIVW:   if (div_stat.done) state_in = S_F_MUL_PQ;
         S_F_MUL_PQ: state_in = S_F_MUL_PP;
         S_F_MUL_PP: state_in = S_F_MUL_QQ;
         S_F_MUL_QQ: state_in = S_F_MUL_HH;
         S_F_MUL_HH: state_in = S_F_WRITE;
         S_F_WRITE:  state_in = (m_ff == nm_last) ? S_M_CLEAR : S_F_SCAN;
         S_M_CLEAR: begin
            rel_we = 1'b1;
            if (clr_ff == {REL_ADDR_W{1'b1}}) begin
               state_in = (den_ff == '0) ? S_DONE : S_M_MAC;
            end
         end
         S_M_MAC:   if (m_ff == nm_last) state_in = S_M_DRAIN;
         S_M_DRAIN: if (!mac_v1_ff && !mac_v2_ff) state_in = S_M_DIV;
         S_M_DIV: begin
            div_start = 1'b1;
            state_in  = S_M_DIVW;
         end
         S_M_DIVW: if (div_stat.done) state_in = S_M_WR1;
         S_M_WR1: begin
            rel_we    = 1'b1;
            rel_waddr = {i_ff, j_ff};
            rel_wdata = res_ff;
            state_in  = S_M_WR2;
         end
         S_M_WR2: begin
            // mirror entry of the symmetric matrix
            rel_we    = 1'b1;
            rel_waddr = {j_ff, i_ff};
            rel_wdata = res_ff;
            state_in  = ((i_ff == ns_last) && (j_ff == ns_last)) ? S_DONE : S_M_MAC;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------- datapath registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_v_ff <= 1'b0;
         mac_v1_ff <= 1'b0;
         mac_v2_ff <= 1'b0;
      end else begin
         scan_v_ff <= (state_ff == S_F_SCAN);
         mac_v1_ff <= (state_ff == S_M_MAC);
         mac_v2_ff <= mac_v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      // allele tally, one genotype per cycle behind the memory read
      if (scan_v_ff && (ga_ff != 2'd3)) begin
         sum_ff <= sum_ff + {6'd0, ga_ff};
         cnt_ff <= cnt_ff + 7'd1;
      end
      if (mac_v2_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end

      unique case (state_ff)
         S_IDLE: begin
            i_ff   <= '0;
            j_ff   <= '0;
            m_ff   <= '0;
            clr_ff <= '0;
            sum_ff <= '0;
            cnt_ff <= '0;
            den_ff <= '0;
            acc_ff <= '0;
         end
         S_F_SCAN: i_ff <= (i_ff == ns_last) ? '0 : i_ff + 1'b1;
         S_F_START: begin
            czero_ff <= (cnt_ff == 7'd0);
            p_ff     <= '0;
         end
         S_F_DIVW:   if (div_stat.done) p_ff <= div_quo[16:0];
         S_F_MUL_PP: het_ff <= prod_rnd[31:15];
         S_F_MUL_QQ: cpp_ff <= prod_rnd[32:15];
         S_F_MUL_HH: cqq_ff <= prod_rnd[32:15];
         S_F_WRITE: begin
            if (!czero_ff) begin
               den_ff <= mode_ff ? den_ff + DEN_W'($unsigned(prod_ff))
                                 : den_ff + {24'd0, het_ff};
            end
            sum_ff <= '0;
            cnt_ff <= '0;
            m_ff   <= (m_ff == nm_last) ? '0 : m_ff + 1'b1;
         end
         S_M_CLEAR: clr_ff <= clr_ff + 1'b1;
         S_M_MAC:   m_ff <= (m_ff == nm_last) ? '0 : m_ff + 1'b1;
         S_M_DIVW:  if (div_stat.done) res_ff <= ratio_val;
         S_M_WR2: begin
            acc_ff <= '0;
            if (j_ff == ns_last) begin
               i_ff <= i_ff + 1'b1;
               j_ff <= i_ff + 1'b1;
            end else begin
               j_ff <= j_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         matrix_ready_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (state_ff == S_RD_WAIT) begin
            rsp_valid_ff  <= 1'b1;
            rsp_value_ff  <= matrix_ready_ff ? rel_rd_ff : 32'd0;
            rsp_status_ff <= ST_READ;
         end else if (state_ff == S_DONE) begin
            rsp_valid_ff    <= 1'b1;
            rsp_value_ff    <= 32'd0;
            rsp_status_ff   <= (den_ff == '0) ? ST_ZERO_DEN : ST_DONE;
            matrix_ready_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_value = signed'(rsp_value_ff);
   assign rsp_status      = rsp_status_ff;

   // ---------------- assertions ----------------
`include "genomic_relationship_matrix_macros.svh"

   `GRM_ASSERT_NOW(a_busy_stalls, state_ff != S_IDLE, req_stall)
   `GRM_ASSERT_NOW(a_mac_in_matrix, mac_v2_ff, state_ff == S_M_MAC || state_ff == S_M_DRAIN)
   `GRM_ASSERT_NOW(a_div_free_at_start, div_start, !div_stat.busy)
   `GRM_ASSERT_NEXT(a_done_reports, state_ff == S_DONE,
                    rsp_valid_ff && rsp_value_ff == 32'd0 && rsp_status_ff != ST_READ)

endmodule

/* tb/testbench.sv */
// self-checking testbench for the genomic relationship matrix engine
module testbench;
   import grm_pkg::*;

   localparam int CYCLE_LIMIT = 20000000;
   localparam int IDLE_WAIT   = 200;

   // one request as offered on the input channel
   typedef struct {
      logic [1:0] command;
      logic [5:0] sample;
      logic [9:0] marker;
      logic [1:0] code;
      logic [5:0] row;
      logic [5:0] col;
   } request_type;

   // one reply as expected on the result channel
   typedef struct {
      logic signed [31:0] entry;
      logic [1:0]         status;
   } reply_type;

   logic clock = 0;
   logic reset = 1;

   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_command = CMD_LOAD;
   logic [5:0]  req_sample_index = 0;
   logic [9:0]  req_marker_index = 0;
   logic [1:0]  req_genotype_code = 0;
   logic [5:0]  req_row_index = 0;
   logic [5:0]  req_col_index = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic signed [31:0] rsp_entry_value;
   logic [1:0]  rsp_status;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [3:0]  csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   genomic_relationship_matrix DUT (.*);

   always #5 clock = ~clock;

   // requests waiting to be offered, replies waiting to arrive
   request_type pending_requests[$];
   reply_type   expected_replies[$];
   int       failures = 0;
   int       cycle_count = 0;

   // shadow of the block state, kept in step with accepted requests
   logic [1:0]  genotype_shadow[MAX_SAMPLES*MAX_MARKERS];
   int          relationship_shadow[MAX_SAMPLES*MAX_SAMPLES];
   int          marker_code[MAX_MARKERS][4];
   bit          matrix_ready = 0;
   bit          dominance = 0;
   int unsigned sample_count = 64;
   int unsigned marker_count = 1024;

   // cells the stimulus has already loaded, so compute never sees an unwritten code
   bit          cell_loaded[MAX_SAMPLES*MAX_MARKERS];

   // long hold-off on the result side, started by the stimulus
   bit          hold_request = 0;

   function automatic int unsigned clamp_count(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic longint unsigned round_frac(longint unsigned v);
      return (v + 64'd32768) >> 16;
   endfunction

   // rounded division, half away from zero, saturated into 32 bits
   function automatic int rounded_quotient(longint num, longint unsigned den, bit scaled);
      longint unsigned mag, q, whole, rem;
      mag = num < 0 ? longint'(0) - num : num;
      if (!scaled) begin
         q = (mag + den / 2) / den;
      end else begin
         whole = mag / den;
         rem   = mag % den;
         if (whole >= 65536) q = 64'd1 << 32;
         else q = (whole << 16) + ((rem << 16) + den / 2) / den;
      end
      if (num >= 0) return q > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : int'(q);
      if (q >= 64'h8000_0000) return 32'h8000_0000;
      return -int'(q);
   endfunction

   // frequency pass, per-marker codes, then the symmetric product
   function automatic logic [1:0] compute_relationship();
      int unsigned sum, cnt, p, q, g, gi, gj;
      longint unsigned het, den;
      longint s;
      int v;
      den = 0;
      for (int m = 0; m < marker_count; m++) begin
         sum = 0;
         cnt = 0;
         p = 0;
         for (int i = 0; i < sample_count; i++) begin
            g = genotype_shadow[i*MAX_MARKERS + m];
            if (g != 3) begin
               sum += g;
               cnt++;
            end
         end
         if (cnt > 0) p = ((longint'(sum) << 16) + cnt) / (2 * longint'(cnt));
         q = 65536 - p;
         het = round_frac(2 * longint'(p) * q);
         if (cnt == 0) begin
            het = 0;
            for (int k = 0; k < 3; k++) marker_code[m][k] = 0;
         end else if (dominance) begin
            marker_code[m][0] = -int'(round_frac(2 * longint'(p) * p));
            marker_code[m][1] = int'(het);
            marker_code[m][2] = -int'(round_frac(2 * longint'(q) * q));
         end else begin
            marker_code[m][0] = -int'(2 * p);
            marker_code[m][1] = 65536 - int'(2 * p);
            marker_code[m][2] = 131072 - int'(2 * p);
         end
         marker_code[m][3] = 0;
         den += dominance ? het * het : het;
      end
      foreach (relationship_shadow[k]) relationship_shadow[k] = 0;
      if (den == 0) return ST_ZERO_DEN;
      for (int i = 0; i < sample_count; i++) begin
         for (int j = i; j < sample_count; j++) begin
            s = 0;
            for (int m = 0; m < marker_count; m++) begin
               gi = genotype_shadow[i*MAX_MARKERS + m];
               gj = genotype_shadow[j*MAX_MARKERS + m];
               s += longint'(marker_code[m][gi]) * marker_code[m][gj];
            end
            v = rounded_quotient(s, den, dominance);
            relationship_shadow[i*MAX_SAMPLES + j] = v;
            relationship_shadow[j*MAX_SAMPLES + i] = v;
         end
      end
      return ST_DONE;
   endfunction

   // update the shadow for one accepted request and queue its reply
   function automatic void apply_request(request_type r);
      reply_type rep;
      case (r.command)
         CMD_LOAD: begin
            genotype_shadow[r.sample*MAX_MARKERS + r.marker] = r.code;
         end
         CMD_COMPUTE: begin
            rep.status = compute_relationship();
            rep.entry  = 0;
            matrix_ready = 1;
            expected_replies.insert(expected_replies.size(), rep);
         end
         CMD_READ: begin
            rep.status = ST_READ;
            rep.entry  = matrix_ready ? relationship_shadow[r.row*MAX_SAMPLES + r.col] : 0;
            expected_replies.insert(expected_replies.size(), rep);
         end
         default: ;  // unused command is dropped without a reply
      endcase
   endfunction

   // request driver: bursts of random length with random gaps between them
   int gap_left = 0;
   int burst_left = 4;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && !req_stall) apply_request(pending_requests.pop_front());
         // a stalled request stays put
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 0;
            end else if (pending_requests.size() > 0) begin
               req_valid         <= 1;
               req_command       <= pending_requests[0].command;
               req_sample_index  <= pending_requests[0].sample;
               req_marker_index  <= pending_requests[0].marker;
               req_genotype_code <= pending_requests[0].code;
               req_row_index     <= pending_requests[0].row;
               req_col_index     <= pending_requests[0].col;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // result-side stall: a changing pattern, plus one long hold-off on request
   int stall_mode = 0;
   int stall_left = 0;
   int hold_left = 0;
   bit hold_done = 0;
   always @(posedge clock) begin
      if (hold_request && !hold_done) begin
         hold_done = 1;
         hold_left = 3000;
      end
      if (stall_left <= 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(20, 300);
      end
      stall_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // reply monitor: compare each accepted reply with the oldest expectation
   always @(posedge clock) begin
      reply_type exp_rep;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_replies.size() == 0) begin
            $error("unexpected reply: entry_value %0d status %0d", rsp_entry_value, rsp_status);
            failures++;
         end else begin
            exp_rep = expected_replies.pop_front();
            if (rsp_entry_value !== exp_rep.entry) begin
               $error("entry_value: expected %0d, actual %0d", exp_rep.entry, rsp_entry_value);
               failures++;
            end
            if (rsp_status !== exp_rep.status) begin
               $error("status: expected %0d, actual %0d", exp_rep.status, rsp_status);
               failures++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // apb write: setup cycle, then access cycle
   task automatic csr_write(logic [1:0] index, logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
      case (index)
         REG_MODE:    dominance = value[0];
         REG_SAMPLES: sample_count = clamp_count(value[6:0], MAX_SAMPLES);
         default:     marker_count = clamp_count(value[10:0], MAX_MARKERS);
      endcase
   endtask

   // let everything drain, plus a margin for a trailing load
   task automatic wait_idle();
      while (pending_requests.size() > 0 || expected_replies.size() > 0)
         @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic push_request(logic [1:0] cmd, int s, int m, int g, int r, int c);
      request_type it;
      it.command = cmd;
      it.sample  = s;
      it.marker  = m;
      it.code    = g;
      it.row     = r;
      it.col     = c;
      if (cmd == CMD_LOAD) cell_loaded[s*MAX_MARKERS + m] = 1;
      pending_requests.insert(pending_requests.size(), it);
   endtask

   // load every cell a compute will read, with a per-marker share of missing codes
   task automatic load_region(bit all_cells);
      int miss;
      for (int m = 0; m < marker_count; m++) begin
         miss = $urandom_range(0, 9) == 0 ? 100 : $urandom_range(0, 30);
         for (int i = 0; i < sample_count; i++) begin
            if (all_cells || !cell_loaded[i*MAX_MARKERS + m])
               push_request(CMD_LOAD, i, m,
                  ($urandom_range(0, 99) < miss) ? 3 : $urandom_range(0, 2), 0, 0);
         end
      end
   endtask

   // random mix of loads, computes and reads over the current settings
   task automatic random_mix(int count);
      int pick, s, r, c;
      push_request(CMD_COMPUTE, 0, 0, 0, 0, 0);
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            s = ($urandom_range(0, 1) == 0) ? $urandom_range(0, sample_count - 1)
                                           : $urandom_range(0, 63);
            push_request(CMD_LOAD, s,
               ($urandom_range(0, 1) == 0) ? $urandom_range(0, marker_count - 1)
                                          : $urandom_range(0, 1023),
               $urandom_range(0, 3), $urandom_range(0, 63), $urandom_range(0, 63));
         end else if (pick < 43) begin
            push_request(CMD_COMPUTE, $urandom_range(0, 63), $urandom_range(0, 1023),
               $urandom_range(0, 3), $urandom_range(0, 63), $urandom_range(0, 63));
         end else if (pick < 97) begin
            r = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                           : $urandom_range(0, sample_count - 1);
            c = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                           : $urandom_range(0, sample_count - 1);
            push_request(CMD_READ, $urandom_range(0, 63), $urandom_range(0, 1023),
               $urandom_range(0, 3), r, c);
         end else begin
            push_request(2'd3, $urandom_range(0, 63), $urandom_range(0, 1023),
               $urandom_range(0, 3), $urandom_range(0, 63), $urandom_range(0, 63));
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;

      // register minimums: out-of-range zero saturates to one sample and one marker
      csr_write(REG_MODE, 0);
      csr_write(REG_SAMPLES, 0);
      csr_write(REG_MARKERS, 0);
      // read before any compute, then the unused command
      push_request(CMD_READ, 0, 0, 0, 0, 0);
      push_request(2'd3, 63, 1023, 3, 63, 63);
      push_request(CMD_LOAD, 63, 1023, 3, 0, 0);
      push_request(CMD_LOAD, 0, 0, 2, 0, 0);
      // fixed marker: zero denominator
      push_request(CMD_COMPUTE, 0, 0, 0, 0, 0);
      push_request(CMD_READ, 0, 0, 0, 0, 0);
      push_request(CMD_READ, 0, 0, 0, 63, 63);
      // all-missing marker: also zero denominator
      push_request(CMD_LOAD, 0, 0, 3, 0, 0);
      push_request(CMD_COMPUTE, 0, 0, 0, 0, 0);
      push_request(CMD_LOAD, 0, 0, 1, 0, 0);
      push_request(CMD_COMPUTE, 0, 0, 0, 0, 0);
      push_request(CMD_READ, 0, 0, 0, 0, 0);
      push_request(CMD_READ, 0, 0, 0, 0, 63);
      wait_idle();

      // dominance on a tiny set with every code
      csr_write(REG_MODE, 1);
      csr_write(REG_SAMPLES, 3);
      csr_write(REG_MARKERS, 2);
      push_request(CMD_LOAD, 0, 0, 0, 0, 0);
      push_request(CMD_LOAD, 1, 0, 1, 0, 0);
      push_request(CMD_LOAD, 2, 0, 2, 0, 0);
      push_request(CMD_LOAD, 0, 1, 2, 0, 0);
      push_request(CMD_LOAD, 1, 1, 3, 0, 0);
      push_request(CMD_LOAD, 2, 1, 2, 0, 0);
      push_request(CMD_COMPUTE, 0, 0, 0, 0, 0);
      for (int k = 0; k < 9; k++) push_request(CMD_READ, 0, 0, 0, k / 3, k % 3);
      push_request(CMD_READ, 0, 0, 0, 2, 63);
      wait_idle();

      // sample maximum (over-range write), few markers; long result hold-off here
      csr_write(REG_SAMPLES, 127);
      csr_write(REG_MARKERS, 3);
      load_region(1);
      hold_request = 1;
      random_mix(150);
      wait_idle();

      // marker maximum (over-range write), one sample, additive
      csr_write(REG_MODE, 0);
      csr_write(REG_SAMPLES, 1);
      csr_write(REG_MARKERS, 2047);
      load_region(1);
      random_mix(80);
      wait_idle();

      // random settings, small sizes
      for (int ph = 0; ph < 8; ph++) begin
         csr_write(REG_MODE, $urandom_range(0, 1));
         csr_write(REG_SAMPLES, $urandom_range(1, 8));
         csr_write(REG_MARKERS, $urandom_range(1, 16));
         if ($urandom_range(0, 1) == 0) load_region(1);
         else load_region(0);
         random_mix(40);
         wait_idle();
      end

      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
